### sv/velocity_command_frame_parser_defines.svh
// Assertion macros shared by the command frame parser RTL
`ifndef VELOCITY_COMMAND_FRAME_PARSER_DEFINES_SVH
`define VELOCITY_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define VCFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define VCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vcfp_pkg.sv
// Types and constants of the velocity command frame parser
`default_nettype none

package vcfp_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN = 14;
    localparam int unsigned POS_W     = 4;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_HDR        = 4'd0;
    localparam pos_t POS_TYPE       = 4'd1;
    localparam pos_t POS_ID         = 4'd2;
    localparam pos_t POS_CMD        = 4'd3;
    localparam pos_t POS_SPEED_X    = 4'd5;
    localparam pos_t POS_SPEED_X_HI = 4'd8;
    localparam pos_t POS_SPEED_W    = 4'd9;
    localparam pos_t POS_SPEED_W_HI = 4'd12;
    localparam pos_t POS_LAST       = 4'(FRAME_LEN - 1);

    // Byte codes
    localparam logic [7:0] HDR_BYTE  = 8'h3E;
    localparam logic [7:0] TYPE_BYTE = 8'hA2;
    localparam logic [7:0] ID_A      = 8'h01;
    localparam logic [7:0] ID_B      = 8'hFE;
    localparam logic [7:0] MODE_FIVE = 8'h05;
    localparam logic [7:0] MODE_SIX  = 8'h06;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_DUTY_FIVE    = 2'd0;
    localparam logic [1:0] CFG_DUTY_SIX     = 2'd1;
    localparam logic [1:0] CFG_DUTY_DEFAULT = 2'd2;

    localparam logic [15:0] DUTY_FIVE_RST    = 16'd90;
    localparam logic [15:0] DUTY_SIX_RST     = 16'd18;
    localparam logic [15:0] DUTY_DEFAULT_RST = 16'd54;

    // Fields of a checked frame
    typedef struct packed {
        logic        ok;
        logic [31:0] speed_x;
        logic [31:0] speed_w;
        logic [7:0]  cmd;
    } frame_t;

endpackage

`default_nettype wire

### sv/vcfp_assembler.sv
// Byte-by-byte frame assembler with running checksum and header checks
`default_nettype none

module vcfp_assembler
    import vcfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_take,
    input  wire logic [7:0] rx_byte,
    output frame_t          frame
);

    pos_t        pos_reg, pos_next;
    logic        type_ok_reg, type_ok_next;
    logic        id_ok_reg, id_ok_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] speed_x_reg, speed_x_next;
    logic [31:0] speed_w_reg, speed_w_next;
    logic [1:0]  lane_x;
    logic [1:0]  lane_w;
    pos_t        off_x;
    pos_t        off_w;

    // Byte lane inside each speed word
    always_comb
    begin
        off_x  = pos_reg - POS_SPEED_X;
        off_w  = pos_reg - POS_SPEED_W;
        lane_x = off_x[1:0];
        lane_w = off_w[1:0];
    end

    // Advance position, collect fields and sum
    always_comb
    begin
        pos_next     = pos_reg;
        type_ok_next = type_ok_reg;
        id_ok_next   = id_ok_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        speed_x_next = speed_x_reg;
        speed_w_next = speed_w_reg;
        if (byte_take)
        begin
            if (pos_reg == POS_HDR)
            begin
                pos_next = (rx_byte == HDR_BYTE) ? POS_TYPE : POS_HDR;
                sum_next = '0;
            end
            else if (pos_reg == POS_LAST)
            begin
                pos_next = POS_HDR;
            end
            else
            begin
                pos_next = pos_reg + pos_t'(1);
            end

            if (pos_reg == POS_TYPE)
            begin
                type_ok_next = (rx_byte == TYPE_BYTE);
            end
            if (pos_reg == POS_ID)
            begin
                id_ok_next = (rx_byte == ID_A) || (rx_byte == ID_B);
            end
            if (pos_reg == POS_CMD)
            begin
                cmd_next = rx_byte;
            end
            if (pos_reg >= POS_SPEED_X && pos_reg <= POS_SPEED_W_HI)
            begin
                sum_next = sum_reg + rx_byte;
            end
            if (pos_reg >= POS_SPEED_X && pos_reg <= POS_SPEED_X_HI)
            begin
                speed_x_next[8*lane_x +: 8] = rx_byte;
            end
            if (pos_reg >= POS_SPEED_W && pos_reg <= POS_SPEED_W_HI)
            begin
                speed_w_next[8*lane_w +: 8] = rx_byte;
            end
        end
    end

    // Check the frame on its last byte
    always_comb
    begin
        frame.ok      = byte_take && (pos_reg == POS_LAST) && type_ok_reg && id_ok_reg
                        && (rx_byte == sum_reg);
        frame.speed_x = speed_x_reg;
        frame.speed_w = speed_w_reg;
        frame.cmd     = cmd_reg;
    end

    // Hold position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HDR;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Hold collected fields
    always_ff @(posedge clk)
    begin
        type_ok_reg <= type_ok_next;
        id_ok_reg   <= id_ok_next;
        cmd_reg     <= cmd_next;
        sum_reg     <= sum_next;
        speed_x_reg <= speed_x_next;
        speed_w_reg <= speed_w_next;
    end

endmodule

`default_nettype wire

### sv/velocity_command_frame_parser.sv
// Velocity command frame parser: top level with duty registers and result buffering
//
// Takes one serial byte per cycle while in_stall is low and assembles 14-byte command
// frames that open with 0x3E; a byte seen while no frame is open is dropped. On the last
// byte the type byte, the id byte and the 8-bit sum of bytes 5..12 are checked against
// values kept while the frame came in, so there is no frame buffer to scan. A good frame
// gives one result in the output register, or in the skid register when the output is
// held: two little-endian signed speeds, the command byte and the duty compare that the
// command selects. The rate is set by the output register and a one-entry skid register
// behind it; in_stall rises only when both hold results the consumer has not taken.
`default_nettype none

`include "velocity_command_frame_parser_defines.svh"

module velocity_command_frame_parser
    import vcfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      speed_x,
    output logic signed [31:0]      speed_w,
    output logic [15:0]             duty_compare,
    output logic [7:0]              command_code
);

    typedef struct packed {
        logic [31:0] speed_x;
        logic [31:0] speed_w;
        logic [15:0] duty;
        logic [7:0]  cmd;
    } result_t;

    logic [15:0] duty_five_reg;
    logic [15:0] duty_six_reg;
    logic [15:0] duty_default_reg;

    logic        byte_take;
    frame_t      frame;
    result_t     res_new;
    logic        res_push;
    logic        out_take;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    assign byte_take = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;

    vcfp_assembler u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .rx_byte   (rx_byte),
        .frame     (frame)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_five_reg    <= DUTY_FIVE_RST;
            duty_six_reg     <= DUTY_SIX_RST;
            duty_default_reg <= DUTY_DEFAULT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DUTY_FIVE:    duty_five_reg    <= cfg_data;
                CFG_DUTY_SIX:     duty_six_reg     <= cfg_data;
                CFG_DUTY_DEFAULT: duty_default_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Form the result of a good frame
    always_comb
    begin
        res_new.speed_x = frame.speed_x;
        res_new.speed_w = frame.speed_w;
        res_new.cmd     = frame.cmd;
        case (frame.cmd)
            MODE_FIVE: res_new.duty = duty_five_reg;
            MODE_SIX:  res_new.duty = duty_six_reg;
            default:   res_new.duty = duty_default_reg;
        endcase
    end

    assign res_push = frame.ok;
    assign out_take = out_valid_reg && !out_stall;

    // Steer results into the output register or the skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_push)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_next       = res_new;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = res_new;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign speed_x      = signed'(out_reg.speed_x);
    assign speed_w      = signed'(out_reg.speed_w);
    assign duty_compare = out_reg.duty;
    assign command_code = out_reg.cmd;

    // Checks
    `VCFP_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output item")
    `VCFP_ASSERT_NEXT(a_skid_fill_when_held, !skid_valid_reg && res_push && out_valid_reg && out_stall, skid_valid_reg, "result lost while output held")
    `VCFP_ASSERT_NEXT(a_out_drains, out_take && !skid_valid_reg && !res_push, !out_valid_reg, "output item repeated")

endmodule

`default_nettype wire
